@@ rtl/core/lg_pkg.sv @@
// ----------------------------------------------------------------------------
// lg_pkg
// Shared types, constants and the cell rule for the Life row engine.
// ----------------------------------------------------------------------------
package lg_pkg;

    // Field width of one packed row and number of live columns
    localparam int ROW_BITS     = 64;
    localparam int GRID_WIDTH   = 64;

    // B3/S23 rule counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_BITS   = 2;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                last_row;
    } row_in_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_cells;
        logic                frame_end;
        logic                run_end;
    } row_out_t;

    // One column's view as seen by its neighbors
    typedef struct packed {
        logic up;   // row above the pending row
        logic mid;  // pending row
        logic cur;  // incoming row
    } lg_col_t;

    // Shift / flush command broadcast to every cell
    typedef struct packed {
        logic shift;
        logic flush;
    } lg_cell_ctrl_t;

    // Next state of one cell from its live-neighbor count
    function automatic logic life_next(input logic [3:0] n, input logic alive);
        return (n == BIRTH_COUNT) || (alive && (n == SURVIVE_COUNT));
    endfunction

endpackage

@@ rtl/core/life_generation_row_engine.sv @@
// ----------------------------------------------------------------------------
// life_generation_row_engine
// Streaming Game of Life (B3/S23) generation engine, one grid row a transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Rows of one generation enter on the row channel (row_valid/row_ready),
//   top row first, with last_row set on the bottom row. Columns wrap left to
//   right; rows above the top and below the bottom are dead.
//   Each row after the first yields the next generation of the row before it
//   on the result channel (result_valid/result_ready). The last row also
//   yields its own result, flagged by frame_end; run_end marks the final
//   result caused by each input transaction.
//   A result is registered in the result queue before it shows on the
//   result channel. Throughput: one row per cycle; the column cells are
//   evaluated in a single pass, so the rate is set by the result queue
//   draining, which a last row after the first loads with two results.
//   Reset clears the held rows and empties the result queue. When the
//   receiver stalls, results collect in a three-slot queue and row_ready
//   drops once fewer than two slots remain free.
// ----------------------------------------------------------------------------
module life_generation_row_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             row_valid,
    output logic             row_ready,
    input  lg_pkg::row_in_t  row_item,
    output logic             result_valid,
    input  logic             result_ready,
    output lg_pkg::row_out_t result_item
);
    import lg_pkg::*;

    logic [1:0]          rows_held_reg, rows_held_next;
    logic                accept;
    lg_cell_ctrl_t       ctrl;
    lg_col_t             col [GRID_WIDTH];
    logic [ROW_BITS-1:0] pend_row;
    logic [ROW_BITS-1:0] last_row_res;
    logic [1:0]          push_cnt;
    row_out_t            push_first;
    row_out_t            push_second;
    logic                room;

    assign accept    = row_valid && row_ready;
    assign row_ready = room;

    // Cell row control
    assign ctrl.shift = accept;
    assign ctrl.flush = accept && row_item.last_row;

    // Chain of column cells, wrapping left to right
    genvar k;
    generate
        for (k = 0; k < GRID_WIDTH; k++)
        begin : g_col
            localparam int LEFT  = (k + GRID_WIDTH - 1) % GRID_WIDTH;
            localparam int RIGHT = (k + 1) % GRID_WIDTH;
            lg_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .cur       (row_item.row_cells[k]),
                .col_left  (col[LEFT]),
                .col_right (col[RIGHT]),
                .col       (col[k]),
                .next_pend (pend_row[k]),
                .next_last (last_row_res[k])
            );
        end
        for (k = GRID_WIDTH; k < ROW_BITS; k++)
        begin : g_pad
            assign pend_row[k]     = 1'b0;
            assign last_row_res[k] = 1'b0;
        end
    endgenerate

    // Results caused by the incoming row
    always_comb
    begin
        push_cnt    = 2'd0;
        push_first  = '{next_cells: pend_row, frame_end: 1'b0,
                        run_end: !row_item.last_row};
        push_second = '{next_cells: last_row_res, frame_end: 1'b1, run_end: 1'b1};
        if (accept)
        begin
            if (rows_held_reg == 2'd0)
            begin
                if (row_item.last_row)
                begin
                    push_cnt   = 2'd1;
                    push_first = push_second;
                end
            end
            else
            begin
                push_cnt = row_item.last_row ? 2'd2 : 2'd1;
            end
        end
    end

    // Rows held in the cell window
    always_comb
    begin
        rows_held_next = rows_held_reg;
        if (accept)
        begin
            if (row_item.last_row)
            begin
                rows_held_next = 2'd0;
            end
            else if (rows_held_reg == 2'd0)
            begin
                rows_held_next = 2'd1;
            end
            else
            begin
                rows_held_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_held_reg <= 2'd0;
        end
        else
        begin
            rows_held_reg <= rows_held_next;
        end
    end

    // Output queue
    lg_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push_first   (push_first),
        .push_second  (push_second),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Checks
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_item.last_row) |=> (rows_held_reg == 2'd0))
        else $error("row window not cleared after last row");

    a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !row_item.last_row && rows_held_reg == 2'd0) |=> (rows_held_reg == 2'd1))
        else $error("first row not held");

    a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.frame_end) |-> result_item.run_end)
        else $error("frame end result without run end");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_held_reg != 2'd3))
        else $error("row window count out of range");

endmodule

@@ rtl/core/lg_cell.sv @@
// ----------------------------------------------------------------------------
// lg_cell
// One grid column: holds the upper and pending row bits of its column and
// computes both candidate next-generation bits from its two neighbors.
// ----------------------------------------------------------------------------
module lg_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lg_pkg::lg_cell_ctrl_t ctrl,
    input  logic                  cur,
    input  lg_pkg::lg_col_t       col_left,
    input  lg_pkg::lg_col_t       col_right,
    output lg_pkg::lg_col_t       col,
    output logic                  next_pend,
    output logic                  next_last
);
    import lg_pkg::*;

    logic       up_reg, up_next;
    logic       mid_reg, mid_next;
    logic [3:0] n_pend;
    logic [3:0] n_last;

    // Column state toward the neighbors
    assign col = '{up: up_reg, mid: mid_reg, cur: cur};

    // Pending row: above = up, here = mid, below = incoming row
    assign n_pend = {3'd0, col_left.up}  + {3'd0, up_reg}  + {3'd0, col_right.up}
                  + {3'd0, col_left.mid} + {3'd0, col_right.mid}
                  + {3'd0, col_left.cur} + {3'd0, cur}     + {3'd0, col_right.cur};
    assign next_pend = life_next(n_pend, mid_reg);

    // Incoming row as final row: above = mid, here = incoming, below = dead
    assign n_last = {3'd0, col_left.mid} + {3'd0, mid_reg} + {3'd0, col_right.mid}
                  + {3'd0, col_left.cur} + {3'd0, col_right.cur};
    assign next_last = life_next(n_last, cur);

    // Row window update
    always_comb
    begin
        up_next  = up_reg;
        mid_next = mid_reg;
        if (ctrl.flush)
        begin
            up_next  = 1'b0;
            mid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            up_next  = mid_reg;
            mid_next = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= 1'b0;
            mid_reg <= 1'b0;
        end
        else
        begin
            up_reg  <= up_next;
            mid_reg <= mid_next;
        end
    end

endmodule

@@ rtl/core/lg_result_queue.sv @@
// ----------------------------------------------------------------------------
// lg_result_queue
// Three-slot shift queue for result rows; takes up to two results a cycle
// and presents the oldest on the output channel.
// ----------------------------------------------------------------------------
module lg_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  lg_pkg::row_out_t push_first,
    input  lg_pkg::row_out_t push_second,
    output logic             room,
    output logic             result_valid,
    input  logic             result_ready,
    output lg_pkg::row_out_t result_item
);
    import lg_pkg::*;

    row_out_t             slot_reg [QUEUE_DEPTH];
    row_out_t             slot_next [QUEUE_DEPTH];
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [QCNT_BITS-1:0] base;
    logic [QCNT_BITS-1:0] base_plus;
    logic                 pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result_item  = slot_reg[0];

    // Occupancy after this cycle's pop; room for two more keeps rate
    assign base      = count_reg - {{(QCNT_BITS-1){1'b0}}, pop};
    assign base_plus = base + {{(QCNT_BITS-1){1'b0}}, 1'b1};
    assign room      = (base <= QCNT_BITS'(1));

    // Shift out on pop, then append new results behind the survivors
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
        end
        if (push_cnt != 2'd0)
        begin
            slot_next[base] = push_first;
        end
        if (push_cnt == 2'd2)
        begin
            slot_next[base_plus] = push_second;
        end
        count_next = base + push_cnt;
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule
